// File: hw/rtl/a85sd_pkg.sv
// ----------------------------------------------------------------------------
// a85sd_pkg
// Shared widths, header patterns, character codes and status codes for the
// base85 stream detector.
// ----------------------------------------------------------------------------
`default_nettype none

package a85sd_pkg;

    // Width of stream positions; all position differences wrap at this width.
    localparam int POS_WIDTH = 32;

    // Header pattern fragments, compared against the low and high halves of
    // the byte window (newest byte in the low byte).
    localparam logic [31:0] HDR_STREAM_LF_LO   = 32'h65616D0A; // "eam\n"
    localparam logic [23:0] HDR_STREAM_HI      = 24'h737472;   // "str"
    localparam logic [31:0] HDR_STREAM_CRLF_LO = 32'h616D0D0A; // "am\r\n"
    localparam logic [31:0] HDR_STREAM_CRLF_HI = 32'h73747265; // "stre"
    localparam logic [31:0] HDR_IMAGE_LO       = 32'h6167650A; // "age\n"
    localparam logic [31:0] HDR_ONIM_HI        = 32'h6F4E696D; // "oNim"
    localparam logic [31:0] HDR_UTIM_HI        = 32'h7574696D; // "utim"
    localparam logic [23:0] HDR_LFIM_HI        = 24'h0A696D;   // "\nim"

    // Character codes.
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_TILDE  = 8'h7E;
    localparam logic [7:0] ALPHA_FIRST = 8'h21;
    localparam logic [7:0] ALPHA_LAST  = 8'h7A;

    // Limits on the captured line length and on the region span.
    localparam logic [POS_WIDTH-1:0] LINE_LEN_MIN_EXCL = POS_WIDTH'(25);
    localparam logic [POS_WIDTH-1:0] LINE_LEN_MAX      = POS_WIDTH'(255);
    localparam logic [POS_WIDTH-1:0] SPAN_MIN_EXCL     = POS_WIDTH'(60);

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_NONE    = 2'd0,
        STATUS_HEADER  = 2'd1,
        STATUS_COLLECT = 2'd2,
        STATUS_FOUND   = 2'd3
    } status_t;

endpackage : a85sd_pkg

`default_nettype wire

// File: hw/rtl/ascii85_stream_detector.sv
// ----------------------------------------------------------------------------
// ascii85_stream_detector
// Scans a byte stream and reports the first base85 encoded region that
// follows a recognised header.
//
//   Channel   Direction  Handshake            Payload
//   in        input      in_valid/in_ready    data_byte, position
//   out       output     out_valid/out_ready  status, region_start, region_end
//   cfg       input      cfg_valid/cfg_ready  max_span
//
// Every accepted byte yields exactly one result, registered in the output or
// skid register; while in_ready is high one byte can be taken every cycle.
// The whole per-byte decision is one window shift, a handful of byte
// compares and two 32-bit subtract-and-compare paths feeding the state and
// result registers.
// A result register followed by a one-entry skid register decouples the two
// sides: a byte is still taken while one result waits, and in_ready drops
// only when both are full.
// Asynchronous active-low reset clears the window, the phase, the stored
// positions and the line length, and sets max_span to all ones.
// cfg_ready is always high; the register is meant to be written while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii85_stream_detector
    import a85sd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [7:0]           data_byte,
    input  wire logic [POS_WIDTH-1:0] position,

    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [1:0]                status,
    output logic [POS_WIDTH-1:0]      region_start,
    output logic [POS_WIDTH-1:0]      region_end,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [31:0]          max_span
);

    // Detector phase. Armed means a header was seen and no character yet.
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_ARMED   = 2'd1,
        PH_COLLECT = 2'd2,
        PH_FOUND   = 2'd3
    } phase_t;

    // Result item as it sits in the output and skid registers.
    typedef struct packed {
        logic [1:0]           status;
        logic [POS_WIDTH-1:0] region_start;
        logic [POS_WIDTH-1:0] region_end;
    } result_t;

    // Detector state.
    logic [63:0]          window_reg, window_next;
    phase_t               phase_reg, phase_next;
    logic [POS_WIDTH-1:0] hdr_pos_reg, hdr_pos_next;
    logic [7:0]           line_len_reg, line_len_next;
    logic [POS_WIDTH-1:0] found_start_reg, found_start_next;
    logic [POS_WIDTH-1:0] found_end_reg, found_end_next;
    logic [31:0]          max_span_reg;

    // Output side.
    result_t              out_reg, skid_reg, result_next;
    logic                 out_valid_reg, skid_valid_reg;

    logic                 in_fire;
    logic                 out_fire;
    logic                 hit;
    logic                 header_hit;
    logic                 is_alpha;
    logic [POS_WIDTH-1:0] line_dist;
    logic [POS_WIDTH-1:0] span;

    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign cfg_ready = 1'b1;

    assign out_valid    = out_valid_reg;
    assign status       = out_reg.status;
    assign region_start = out_reg.region_start;
    assign region_end   = out_reg.region_end;

    // The new byte enters at the bottom of the window before any header
    // compare, so a header is recognised on its final byte.
    assign window_next = {window_reg[55:0], data_byte};

    always_comb
    begin
        header_hit =
            (window_next[31:0] == HDR_STREAM_LF_LO && window_next[55:32] == HDR_STREAM_HI) ||
            (window_next[31:0] == HDR_STREAM_CRLF_LO
                && window_next[63:32] == HDR_STREAM_CRLF_HI) ||
            (window_next[31:0] == HDR_IMAGE_LO
                && (window_next[63:32] == HDR_ONIM_HI
                    || window_next[63:32] == HDR_UTIM_HI
                    || window_next[55:32] == HDR_LFIM_HI));
    end

    assign is_alpha = (data_byte >= ALPHA_FIRST && data_byte <= ALPHA_LAST)
                      || data_byte == CHAR_LF || data_byte == CHAR_CR;

    // Distance from the header to this byte, and the span of the encoded
    // region that a tilde here would close. Both wrap at the position width.
    assign line_dist = position - hdr_pos_reg;
    assign span      = position - POS_WIDTH'(1) - hdr_pos_reg;

    always_comb
    begin
        phase_next       = phase_reg;
        hdr_pos_next     = hdr_pos_reg;
        line_len_next    = line_len_reg;
        found_start_next = found_start_reg;
        found_end_next   = found_end_reg;
        hit              = 1'b0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (header_hit)
                begin
                    phase_next    = PH_ARMED;
                    hdr_pos_next  = position;
                    line_len_next = '0;
                end
            end
            PH_ARMED, PH_COLLECT:
            begin
                // The first CR after the header fixes the line length; a
                // line that is too short or too long cancels the region.
                priority if (data_byte == CHAR_CR && line_len_reg == '0)
                begin
                    if (line_dist <= LINE_LEN_MIN_EXCL || line_dist > LINE_LEN_MAX)
                        phase_next = PH_IDLE;
                    else
                        line_len_next = line_dist[7:0];
                end
                else if (data_byte == CHAR_TILDE)
                begin
                    phase_next = PH_IDLE;
                    if (span > SPAN_MIN_EXCL && span < max_span_reg)
                    begin
                        found_start_next = hdr_pos_reg + POS_WIDTH'(1);
                        found_end_next   = position;
                        phase_next       = PH_FOUND;
                        hit              = 1'b1;
                    end
                end
                else if (is_alpha)
                    phase_next = PH_COLLECT;
                else
                    phase_next = PH_IDLE;
            end
            PH_FOUND:
            begin
                // Holds until reset.
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_next.region_start = found_start_next;
        result_next.region_end   = found_end_next;
        priority if (hit)
            result_next.status = STATUS_FOUND;
        else if (phase_next == PH_ARMED || phase_next == PH_FOUND)
            result_next.status = STATUS_HEADER;
        else if (phase_next == PH_COLLECT)
            result_next.status = STATUS_COLLECT;
        else
            result_next.status = STATUS_NONE;
    end

    // State, configuration register and output buffering.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg      <= '0;
            phase_reg       <= PH_IDLE;
            hdr_pos_reg     <= '0;
            line_len_reg    <= '0;
            found_start_reg <= '0;
            found_end_reg   <= '0;
            max_span_reg    <= '1;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
            out_reg         <= '0;
            skid_reg        <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                max_span_reg <= max_span;

            if (in_fire)
            begin
                window_reg      <= window_next;
                phase_reg       <= phase_next;
                hdr_pos_reg     <= hdr_pos_next;
                line_len_reg    <= line_len_next;
                found_start_reg <= found_start_next;
                found_end_reg   <= found_end_next;
            end

            // A waiting skid entry moves up as soon as the output is taken.
            // Without one, a new result goes straight to the output register
            // when it is free or being drained, otherwise into the skid.
            if (skid_valid_reg)
            begin
                if (out_ready)
                begin
                    out_reg        <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (in_fire)
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_reg       <= result_next;
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_reg       <= result_next;
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The skid entry is only ever filled behind a waiting output.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a pending output");

    // A reported region is final until reset.
    a_found_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_FOUND |=> phase_reg == PH_FOUND)
        else $error("detector left the found phase");

    // A captured line length always lies in the permitted range.
    a_line_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        line_len_reg != '0 |-> line_len_reg > 8'd25)
        else $error("line length captured out of range");

    // The region positions stay clear until a region has been found.
    a_found_clear: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_FOUND |-> found_start_reg == '0 && found_end_reg == '0)
        else $error("region positions set without a find");

    // A byte that closes a region leaves the detector in the found phase.
    a_hit_to_found: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && hit |=> phase_reg == PH_FOUND && found_end_reg == $past(position))
        else $error("region hit not recorded");

endmodule : ascii85_stream_detector

`default_nettype wire
